[src/lvpt_pkg.sv]
`default_nettype none
package lvpt_pkg;

  localparam int ChannelsDefault = 2;

  localparam int DurationW = 11;
  localparam int LockoutW  = 16;
  localparam int MaskW     = 2;
  localparam int IndexW    = 8;
  localparam int CountW    = 32;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;

  localparam logic [DurationW-1:0] DurationMin   = 11'd100;
  localparam logic [DurationW-1:0] DurationMax   = 11'd2000;
  localparam logic [DurationW-1:0] DurationReset = 11'd500;
  localparam logic [LockoutW-1:0]  LockoutReset  = 16'd1000;
  localparam logic [MaskW-1:0]     MaskReset     = 2'd3;
  localparam logic [DurationW-1:0] ElapsedMax    = 11'd2047;
  localparam logic [LockoutW-1:0]  SinceMax      = 16'hFFFF;

  // config register indexes
  localparam logic [CfgIndexW-1:0] CfgDuration = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgLockout  = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgMask     = 2'd2;

  // reject codes
  localparam logic [1:0] ReasonNone     = 2'd0;
  localparam logic [1:0] ReasonBadIndex = 2'd1;
  localparam logic [1:0] ReasonBusy     = 2'd2;
  localparam logic [1:0] ReasonLockout  = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [IndexW-1:0] valve_index;
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic [1:0]        reject_reason;
    logic [MaskW-1:0]  drive_levels;
    logic [MaskW-1:0]  pulsing_mask;
    logic [MaskW-1:0]  open_mask;
    logic [MaskW-1:0]  changed_mask;
    logic [CountW-1:0] pulse_total;
  } res_t;

  typedef struct packed {
    logic [DurationW-1:0] duration;
    logic [LockoutW-1:0]  lockout;
    logic [MaskW-1:0]     active_high;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic start;
  } chan_ctl_t;

  typedef struct packed {
    logic                running;
    logic                running_next;
    logic                open_next;
    logic                ended;
    logic [LockoutW-1:0] since;
    logic [CountW-1:0]   count;
    logic [CountW-1:0]   count_next;
  } chan_stat_t;

endpackage
`default_nettype wire

[src/latching_valve_pulse_timer.sv]
`default_nettype none
// Latching valve pulse timer.
// Path: an accepted cmd beat goes through the input register, then one pass of
//   per-channel update logic into the result register, to become its res beat.
// Throughput: 1 item per cycle while the result channel is not stalled.
// Reset (rst, sync, active high): all channels idle and closed, counters zero,
//   config back to duration 500, lockout 1000, channels in the mask register active high.
module latching_valve_pulse_timer #(
  parameter int CHANNELS = lvpt_pkg::ChannelsDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // command / tick channel
  input  wire logic                           cmd_valid,
  output logic                                cmd_stall,
  input  wire lvpt_pkg::cmd_t                 cmd,
  // result channel
  output logic                                res_valid,
  input  wire logic                           res_stall,
  output lvpt_pkg::res_t                      res,
  // config write port
  input  wire logic                           cfg_we,
  input  wire logic [lvpt_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [lvpt_pkg::CfgDataW-1:0]  cfg_data
);
  import lvpt_pkg::*;

  localparam int PadW = CHANNELS + MaskW;

  cfg_t cfg;

  // input register
  cmd_t cmd_q;
  logic cmd_q_valid;
  logic cmd_take;
  logic advance;

  chan_ctl_t  ctl  [CHANNELS];
  chan_stat_t stat [CHANNELS];

  logic                is_tick;
  logic                idx_ok;
  logic                sel_running;
  logic [LockoutW-1:0] sel_since;
  logic [CountW-1:0]   sel_count;
  logic [CountW-1:0]   sel_count_next;
  logic                start_ok;

  logic [CHANNELS-1:0] running_vec;
  logic [CHANNELS-1:0] open_vec;
  logic [CHANNELS-1:0] changed_vec;
  logic [CHANNELS-1:0] ah_vec;
  logic [CHANNELS-1:0] level_vec;
  logic [PadW-1:0]     running_pad;
  logic [PadW-1:0]     open_pad;
  logic [PadW-1:0]     changed_pad;
  logic [PadW-1:0]     level_pad;

  res_t res_next;

  lvpt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the pipe moves whenever the result slot is empty or draining.
  assign advance   = cmd_q_valid && (!res_valid || !res_stall);
  assign cmd_stall = cmd_q_valid && !advance;
  assign cmd_take  = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (cmd_take) begin
      cmd_q_valid <= 1'b1;
    end else if (advance) begin
      cmd_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_q <= cmd;
    end
  end

  // Decode of the registered item
  assign is_tick = !cmd_q.req_type;
  assign idx_ok  = cmd_q.valve_index < IndexW'(CHANNELS);

  // addressed channel, picked by compare so any index value is safe
  always_comb begin
    sel_running    = 1'b0;
    sel_since      = '0;
    sel_count      = '0;
    sel_count_next = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (cmd_q.valve_index == IndexW'(i)) begin
        sel_running    = stat[i].running;
        sel_since      = stat[i].since;
        sel_count      = stat[i].count;
        sel_count_next = stat[i].count_next;
      end
    end
  end

  // busy check wins over lockout
  assign start_ok = !is_tick && idx_ok && !sel_running && (sel_since >= cfg.lockout);

  // Per-channel timers: step only on the cycle an item is consumed.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    assign ctl[g].tick  = advance && is_tick;
    assign ctl[g].start = advance && start_ok && (cmd_q.valve_index == IndexW'(g));

    lvpt_chan u_chan (
      .clk      (clk),
      .rst      (rst),
      .duration (cfg.duration),
      .ctl      (ctl[g]),
      .stat     (stat[g])
    );

    assign running_vec[g] = stat[g].running_next;
    assign open_vec[g]    = stat[g].open_next;
    assign changed_vec[g] = stat[g].ended || ctl[g].start;
  end

  // Channels past the mask register are active low.
  assign ah_vec    = CHANNELS'({{CHANNELS{1'b0}}, cfg.active_high});
  assign level_vec = ~(running_vec ^ ah_vec);

  // Pad so a single-channel build still yields full-width masks.
  assign running_pad = {{MaskW{1'b0}}, running_vec};
  assign open_pad    = {{MaskW{1'b0}}, open_vec};
  assign changed_pad = {{MaskW{1'b0}}, changed_vec};
  assign level_pad   = {{MaskW{1'b0}}, level_vec};

  always_comb begin
    res_next.drive_levels = level_pad[MaskW-1:0];
    res_next.pulsing_mask = running_pad[MaskW-1:0];
    res_next.open_mask    = open_pad[MaskW-1:0];
    res_next.changed_mask = changed_pad[MaskW-1:0];
    if (is_tick) begin
      res_next.accepted      = 1'b1;
      res_next.reject_reason = ReasonNone;
      res_next.pulse_total   = '0;
    end else if (!idx_ok) begin
      res_next.accepted      = 1'b0;
      res_next.reject_reason = ReasonBadIndex;
      res_next.pulse_total   = '0;
    end else if (sel_running) begin
      res_next.accepted      = 1'b0;
      res_next.reject_reason = ReasonBusy;
      res_next.pulse_total   = sel_count;
    end else if (!start_ok) begin
      res_next.accepted      = 1'b0;
      res_next.reject_reason = ReasonLockout;
      res_next.pulse_total   = sel_count;
    end else begin
      res_next.accepted      = 1'b1;
      res_next.reject_reason = ReasonNone;
      res_next.pulse_total   = sel_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

[src/lvpt_cfg.sv]
`default_nettype none
module lvpt_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lvpt_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [lvpt_pkg::CfgDataW-1:0]  cfg_data,
  output lvpt_pkg::cfg_t                      cfg
);
  import lvpt_pkg::*;

  logic [DurationW-1:0] dur_raw;
  logic [DurationW-1:0] dur_clamped;

  assign dur_raw = cfg_data[DurationW-1:0];

  always_comb begin
    if (dur_raw < DurationMin) begin
      dur_clamped = DurationMin;
    end else if (dur_raw > DurationMax) begin
      dur_clamped = DurationMax;
    end else begin
      dur_clamped = dur_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duration    <= DurationReset;
      cfg.lockout     <= LockoutReset;
      cfg.active_high <= MaskReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgDuration: cfg.duration    <= dur_clamped;
        CfgLockout:  cfg.lockout     <= cfg_data[LockoutW-1:0];
        CfgMask:     cfg.active_high <= cfg_data[MaskW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule
`default_nettype wire

[src/lvpt_chan.sv]
`default_nettype none
module lvpt_chan (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [lvpt_pkg::DurationW-1:0] duration,
  input  wire lvpt_pkg::chan_ctl_t            ctl,
  output lvpt_pkg::chan_stat_t                stat
);
  import lvpt_pkg::*;

  logic                 running;
  logic                 valve_open;
  logic [DurationW-1:0] elapsed;
  logic [LockoutW-1:0]  since;
  logic [CountW-1:0]    count;

  logic [DurationW-1:0] elapsed_inc;
  logic [LockoutW-1:0]  since_inc;
  logic                 ended;

  assign elapsed_inc = (elapsed != ElapsedMax) ? elapsed + 1'b1 : elapsed;
  assign since_inc   = (since != SinceMax) ? since + 1'b1 : since;
  assign ended       = ctl.tick && running && (elapsed_inc >= duration);

  assign stat.running      = running;
  assign stat.running_next = ctl.start || (running && !ended);
  assign stat.open_next    = valve_open ^ ended;
  assign stat.ended        = ended;
  assign stat.since        = since;
  assign stat.count        = count;
  assign stat.count_next   = count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      valve_open <= 1'b0;
      elapsed    <= '0;
      since      <= '0;
      count      <= '0;
    end else if (ctl.tick) begin
      since      <= since_inc;
      valve_open <= valve_open ^ ended;
      if (running) begin
        elapsed <= elapsed_inc;
        running <= !ended;
      end
    end else if (ctl.start) begin
      since   <= '0;
      elapsed <= '0;
      running <= 1'b1;
      count   <= stat.count_next;
    end
  end

endmodule
`default_nettype wire
